>>> sv/cmap_pkg.sv
`timescale 1ns / 1ps

package cmap_pkg;

   localparam int MAX_SEGMENTS = 64;
   localparam int GLYPH_WORDS  = 1024;

   localparam int SEG_AW   = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
   localparam int GLYPH_AW = (GLYPH_WORDS > 1) ? $clog2(GLYPH_WORDS) : 1;
   localparam int CNT_W    = $clog2(MAX_SEGMENTS + 1);
   localparam int IDX_W    = CNT_W + 18;

   localparam int ACTION_W = 2;
   localparam int SLOT_W   = 10;
   localparam int WORD_W   = 16;
   localparam int CFG_W    = 7;

   typedef enum logic [ACTION_W-1:0] {
      ACT_SEG_WRITE   = 2'd0,
      ACT_GLYPH_WRITE = 2'd1,
      ACT_LOOKUP      = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      RES_MISS  = 2'd0,
      RES_DELTA = 2'd1,
      RES_FAULT = 2'd2,
      RES_GLYPH = 2'd3
   } res_kind_type;

   typedef struct packed {
      logic [WORD_W-1:0] seg_end;
      logic [WORD_W-1:0] seg_start;
      logic [WORD_W-1:0] seg_delta;
      logic [WORD_W-1:0] seg_range;
   } seg_type;

   typedef struct packed {
      logic         cfg_we;
      logic         seg_we;
      logic         glyph_we;
      logic         scan_init;
      logic         scan_step;
      logic         seg_latch;
      logic         res_load;
      res_kind_type res_kind;
   } cmd_type;

   typedef struct packed {
      logic hit;
      logic miss;
      logic range_zero;
      logic fault;
   } stat_type;

endpackage

>>> sv/cmap_ram.sv
`timescale 1ns / 1ps

module cmap_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> sv/cmap_ctrl.sv
`timescale 1ns / 1ps

module cmap_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [1:0]         req_action,
   input  logic               csr_valid,
   input  cmap_pkg::stat_type stat,
   output cmap_pkg::cmd_type  cmd,
   output logic               busy,
   output logic               csr_ready
);
   import cmap_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_CALC,
      ST_GWAIT
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            cmd.cfg_we = csr_valid;
            if (start) begin
               case (req_action)
                  ACT_SEG_WRITE:   cmd.seg_we = 1'b1;
                  ACT_GLYPH_WRITE: cmd.glyph_we = 1'b1;
                  ACT_LOOKUP: begin
                     cmd.scan_init = 1'b1;
                     state_in      = ST_SCAN;
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.hit) begin
               cmd.seg_latch = 1'b1;
               state_in      = ST_CALC;
            end else if (stat.miss) begin
               cmd.res_load = 1'b1;
               cmd.res_kind = RES_MISS;
               state_in     = ST_IDLE;
            end
         end
         ST_CALC: begin
            if (stat.range_zero) begin
               cmd.res_load = 1'b1;
               cmd.res_kind = RES_DELTA;
               state_in     = ST_IDLE;
            end else if (stat.fault) begin
               cmd.res_load = 1'b1;
               cmd.res_kind = RES_FAULT;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_GWAIT;
            end
         end
         ST_GWAIT: begin
            cmd.res_load = 1'b1;
            cmd.res_kind = RES_GLYPH;
            state_in     = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE);

endmodule

>>> sv/cmap_dp.sv
`timescale 1ns / 1ps

module cmap_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  cmap_pkg::cmd_type             cmd,
   output cmap_pkg::stat_type            stat,
   input  logic [cmap_pkg::CFG_W-1:0]    csr_data,
   input  logic [cmap_pkg::SLOT_W-1:0]   req_slot,
   input  logic [cmap_pkg::WORD_W-1:0]   req_segment_end,
   input  logic [cmap_pkg::WORD_W-1:0]   req_segment_start,
   input  logic [cmap_pkg::WORD_W-1:0]   req_segment_delta,
   input  logic [cmap_pkg::WORD_W-1:0]   req_segment_range_offset,
   input  logic [cmap_pkg::WORD_W-1:0]   req_glyph_word,
   input  logic [cmap_pkg::WORD_W-1:0]   req_char_code,
   output logic                          rsp_strobe,
   output logic [cmap_pkg::WORD_W-1:0]   rsp_glyph_num,
   output logic                          rsp_matched,
   output logic                          rsp_index_fault
);
   import cmap_pkg::*;

   logic [CFG_W-1:0]    seg_count_ff;
   logic [WORD_W-1:0]   code_ff;
   logic [CNT_W-1:0]    n_ff;
   logic [CNT_W-1:0]    issue_ff;
   logic [CNT_W-1:0]    pidx_ff;
   logic                pend_ff;
   logic [WORD_W-1:0]   start_ff;
   logic [WORD_W-1:0]   delta_ff;
   logic [WORD_W-1:0]   range_ff;
   logic [CNT_W-1:0]    seg_idx_ff;
   logic                strobe_ff;
   logic [WORD_W-1:0]   glyph_num_ff;
   logic                matched_ff;
   logic                fault_ff;

   logic [CNT_W-1:0]    n_clamped;
   logic                issue_valid;
   seg_type             seg_wdata;
   seg_type             seg_rdata;
   logic                seg_slot_ok;
   logic                glyph_slot_ok;
   logic [WORD_W-1:0]   glyph_rdata;
   logic [IDX_W-1:0]    glyph_idx;
   logic                idx_negative;
   logic [WORD_W-1:0]   glyph_sum;

   function automatic logic req_code_le_end(input logic [WORD_W-1:0] code,
                                            input logic [WORD_W-1:0] seg_end);
      return code <= seg_end;
   endfunction

   // Segment table: the four per-segment fields share one address.
   assign seg_wdata.seg_end   = req_segment_end;
   assign seg_wdata.seg_start = req_segment_start;
   assign seg_wdata.seg_delta = req_segment_delta;
   assign seg_wdata.seg_range = req_segment_range_offset;
   assign seg_slot_ok   = (32'(req_slot) < MAX_SEGMENTS);
   assign glyph_slot_ok = (32'(req_slot) < GLYPH_WORDS);

   cmap_ram #(
      .WIDTH ($bits(seg_type)),
      .DEPTH (MAX_SEGMENTS)
   ) u_seg_ram (
      .clock (clock),
      .we    (cmd.seg_we & seg_slot_ok),
      .waddr (SEG_AW'(req_slot)),
      .wdata (seg_wdata),
      .raddr (SEG_AW'(issue_ff)),
      .rdata (seg_rdata)
   );

   cmap_ram #(
      .WIDTH (WORD_W),
      .DEPTH (GLYPH_WORDS)
   ) u_glyph_ram (
      .clock (clock),
      .we    (cmd.glyph_we & glyph_slot_ok),
      .waddr (GLYPH_AW'(req_slot)),
      .wdata (req_glyph_word),
      .raddr (glyph_idx[GLYPH_AW-1:0]),
      .rdata (glyph_rdata)
   );

   assign n_clamped = (32'(seg_count_ff) > MAX_SEGMENTS) ? CNT_W'(MAX_SEGMENTS)
                                                          : CNT_W'(seg_count_ff);
   assign issue_valid = (issue_ff < n_ff);

   // The read issued last cycle is compared while the next one goes out.
   assign stat.hit  = pend_ff && (req_code_le_end(code_ff, seg_rdata.seg_end))
                      && (seg_rdata.seg_start <= code_ff);
   assign stat.miss = !pend_ff && !issue_valid;

   // Glyph array index of the matched segment, signed in two's complement.
   assign glyph_idx = IDX_W'(range_ff >> 1) + IDX_W'(code_ff - start_ff)
                      + IDX_W'(seg_idx_ff) - IDX_W'(n_ff);
   assign idx_negative    = glyph_idx[IDX_W-1];
   assign stat.range_zero = (range_ff == '0);
   assign stat.fault      = idx_negative || (glyph_idx >= IDX_W'(GLYPH_WORDS));

   assign glyph_sum = (glyph_rdata == '0) ? '0 : WORD_W'(glyph_rdata + delta_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_count_ff <= '0;
         strobe_ff    <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         if (cmd.cfg_we) begin
            seg_count_ff <= csr_data;
         end
         strobe_ff <= cmd.res_load;
         if (cmd.scan_init) begin
            pend_ff <= 1'b0;
         end else if (cmd.scan_step) begin
            pend_ff <= issue_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_init) begin
         code_ff  <= req_char_code;
         n_ff     <= n_clamped;
         issue_ff <= '0;
      end else if (cmd.scan_step && issue_valid) begin
         issue_ff <= issue_ff + 1'b1;
      end
      if (cmd.scan_step) begin
         pidx_ff <= issue_ff;
      end
      if (cmd.seg_latch) begin
         start_ff   <= seg_rdata.seg_start;
         delta_ff   <= seg_rdata.seg_delta;
         range_ff   <= seg_rdata.seg_range;
         seg_idx_ff <= pidx_ff;
      end
      if (cmd.res_load) begin
         case (cmd.res_kind)
            RES_MISS: begin
               glyph_num_ff <= '0;
               matched_ff   <= 1'b0;
               fault_ff     <= 1'b0;
            end
            RES_DELTA: begin
               glyph_num_ff <= WORD_W'(code_ff + delta_ff);
               matched_ff   <= 1'b1;
               fault_ff     <= 1'b0;
            end
            RES_FAULT: begin
               glyph_num_ff <= '0;
               matched_ff   <= 1'b1;
               fault_ff     <= 1'b1;
            end
            RES_GLYPH: begin
               glyph_num_ff <= glyph_sum;
               matched_ff   <= 1'b1;
               fault_ff     <= 1'b0;
            end
            default: begin
               glyph_num_ff <= '0;
               matched_ff   <= 1'b0;
               fault_ff     <= 1'b0;
            end
         endcase
      end
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_glyph_num   = glyph_num_ff;
   assign rsp_matched     = matched_ff;
   assign rsp_index_fault = fault_ff;

endmodule

>>> sv/cmap_segment_glyph_lookup.sv
`timescale 1ns / 1ps

// Segment-based character-to-glyph mapper.
// Input transactions arrive on the req_ ports and are taken at a clock edge
// with start high and busy low. A segment write (action 0) stores one segment
// and a glyph write (action 1) stores one glyph array word; both complete in
// the accepting cycle, give no result, and the block is ready again at once.
// A lookup (action 2) scans the active segments one per cycle through the
// segment table's single read port, in order, and takes the first segment
// that covers the code. A lookup issues the first segment read, compares the
// segments in turn, forms the glyph array index on a match, and then reads
// the glyph array; a zero range offset or an index fault ends the lookup
// without that read. At most 64 segments are active. busy stays high until
// the result is shown.
// Each result appears on the rsp_ ports for exactly one cycle with rsp_strobe
// high; the receiver cannot stall, and the block accepts new transactions
// while the strobe is shown. The segment_count register is written on the
// csr_ channel while the block is idle. Synchronous reset clears the count
// and the control state; table contents are undefined until written.
module cmap_segment_glyph_lookup (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [cmap_pkg::ACTION_W-1:0] req_action,
   input  logic [cmap_pkg::SLOT_W-1:0]   req_slot,
   input  logic [cmap_pkg::WORD_W-1:0]   req_segment_end,
   input  logic [cmap_pkg::WORD_W-1:0]   req_segment_start,
   input  logic [cmap_pkg::WORD_W-1:0]   req_segment_delta,
   input  logic [cmap_pkg::WORD_W-1:0]   req_segment_range_offset,
   input  logic [cmap_pkg::WORD_W-1:0]   req_glyph_word,
   input  logic [cmap_pkg::WORD_W-1:0]   req_char_code,
   output logic                          rsp_strobe,
   output logic [cmap_pkg::WORD_W-1:0]   rsp_glyph_num,
   output logic                          rsp_matched,
   output logic                          rsp_index_fault,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [cmap_pkg::CFG_W-1:0]    csr_data
);
   import cmap_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // The controller sequences the scan; the datapath owns the tables.
   cmap_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_action (req_action),
      .csr_valid  (csr_valid),
      .stat       (stat),
      .cmd        (cmd),
      .busy       (busy),
      .csr_ready  (csr_ready)
   );

   cmap_dp u_dp (
      .clock                    (clock),
      .reset                    (reset),
      .cmd                      (cmd),
      .stat                     (stat),
      .csr_data                 (csr_data),
      .req_slot                 (req_slot),
      .req_segment_end          (req_segment_end),
      .req_segment_start        (req_segment_start),
      .req_segment_delta        (req_segment_delta),
      .req_segment_range_offset (req_segment_range_offset),
      .req_glyph_word           (req_glyph_word),
      .req_char_code            (req_char_code),
      .rsp_strobe               (rsp_strobe),
      .rsp_glyph_num            (rsp_glyph_num),
      .rsp_matched              (rsp_matched),
      .rsp_index_fault          (rsp_index_fault)
   );

endmodule

>>> sv/cmap_checker.sv
`timescale 1ns / 1ps

module cmap_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic [cmap_pkg::ACTION_W-1:0] req_action,
   input logic                          rsp_strobe,
   input logic [cmap_pkg::WORD_W-1:0]   rsp_glyph_num,
   input logic                          rsp_matched,
   input logic                          rsp_index_fault
);
   import cmap_pkg::*;

   // An accepted lookup always makes the block busy in the following cycle.
   a_lookup_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_action == ACT_LOOKUP) |=> busy)
      else $error("lookup accepted without going busy");

   // Table writes finish in the accepting cycle.
   a_write_idle: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_action == ACT_SEG_WRITE || req_action == ACT_GLYPH_WRITE))
      |=> !busy)
      else $error("table write held the block busy");

   // Each lookup passes through the scan state, so results are never back to back.
   a_strobe_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("two results in consecutive cycles");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_matched) |-> (rsp_glyph_num == '0 && !rsp_index_fault))
      else $error("unmatched result carries data");

   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_index_fault) |-> (rsp_glyph_num == '0 && rsp_matched))
      else $error("faulted result carries a glyph");

endmodule

bind cmap_segment_glyph_lookup cmap_checker u_cmap_checker (.*);
